// File: rtl/gcib_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcib_pkg
// Shared types, constants and the arctangent table for the bearing pipeline.
// ----------------------------------------------------------------------------
package gcib_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int ANG_W         = 32;
    localparam int TRIG_W        = 33;
    localparam int VEC_W         = 36;
    localparam int ATAN_W        = 30;
    localparam int TENTHS_W      = 12;

    localparam logic [TENTHS_W-1:0] FULL_CIRCLE = 12'd3600;
    localparam logic [ANG_W-1:0]    GAIN_INV    = 32'd652032874;

    typedef struct packed {
        logic [ANG_W-1:0] lat1;
        logic [ANG_W-1:0] lat2;
        logic [ANG_W-1:0] dlon;
        logic             same;
    } item_t;

    typedef struct packed {
        logic valid;
        logic skip;
    } tag_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] k);
        logic [ATAN_W-1:0] r;
        begin
            case (k)
                5'd0:    r = 30'd536870912;
                5'd1:    r = 30'd316933406;
                5'd2:    r = 30'd167458907;
                5'd3:    r = 30'd85004756;
                5'd4:    r = 30'd42667331;
                5'd5:    r = 30'd21354465;
                5'd6:    r = 30'd10679838;
                5'd7:    r = 30'd5340245;
                5'd8:    r = 30'd2670163;
                5'd9:    r = 30'd1335087;
                5'd10:   r = 30'd667544;
                5'd11:   r = 30'd333772;
                5'd12:   r = 30'd166886;
                5'd13:   r = 30'd83443;
                5'd14:   r = 30'd41722;
                5'd15:   r = 30'd20861;
                5'd16:   r = 30'd10430;
                5'd17:   r = 30'd5215;
                5'd18:   r = 30'd2608;
                5'd19:   r = 30'd1304;
                5'd20:   r = 30'd652;
                5'd21:   r = 30'd326;
                5'd22:   r = 30'd163;
                5'd23:   r = 30'd81;
                5'd24:   r = 30'd41;
                5'd25:   r = 30'd20;
                5'd26:   r = 30'd10;
                5'd27:   r = 30'd5;
                5'd28:   r = 30'd3;
                5'd29:   r = 30'd1;
                5'd30:   r = 30'd1;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/great_circle_initial_bearing.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_initial_bearing
// Initial great-circle bearing between two points, in tenths of a degree.
// ----------------------------------------------------------------------------
// Pulse start with a point pair while busy is low; the item is taken at that
// edge. One item per cycle is sustained. Each item yields exactly one result,
// shown on bearing_tenths for one cycle with done high; the receiver must take
// it then. done follows the accepting edge through the input queue, the
// sine/cosine and atan2 CORDIC pipelines and the product and scaling
// registers. busy rises only if the two-entry input queue fills, which does
// not happen when start is at most one per cycle.
module great_circle_initial_bearing (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] from_latitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] from_longitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] to_latitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] to_longitude,
    output logic                               done,
    output logic [gcib_pkg::TENTHS_W-1:0]      bearing_tenths
);

    logic            item_valid;
    gcib_pkg::item_t item;

    gcib_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .from_latitude  (from_latitude),
        .from_longitude (from_longitude),
        .to_latitude    (to_latitude),
        .to_longitude   (to_longitude),
        .item_valid     (item_valid),
        .item           (item)
    );

    gcib_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .done           (done),
        .bearing_tenths (bearing_tenths)
    );

endmodule
`default_nettype wire

// File: rtl/gcib_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcib_front
// Accepts point pairs, forms the longitude difference, flags identical points
// and holds items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gcib_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] from_latitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] from_longitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] to_latitude,
    input  wire logic signed [gcib_pkg::ANG_W-1:0] to_longitude,
    output logic                               item_valid,
    output gcib_pkg::item_t                    item
);

    gcib_pkg::item_t mem_reg [0:1];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;
    gcib_pkg::item_t in_item;

    always_comb
    begin
        in_item.lat1 = from_latitude;
        in_item.lat2 = to_latitude;
        in_item.dlon = to_longitude - from_longitude;
        in_item.same = (from_latitude == to_latitude) && (from_longitude == to_longitude);
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign pop        = (count_reg != 2'd0);
    assign item_valid = pop;
    assign item       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/gcib_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcib_sincos
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle in Q30.
// ----------------------------------------------------------------------------
module gcib_sincos (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gcib_pkg::tag_t                tag_in,
    input  wire logic [gcib_pkg::ANG_W-1:0]    angle,
    output gcib_pkg::tag_t                     tag_out,
    output logic signed [gcib_pkg::ANG_W-1:0]  sin_q,
    output logic signed [gcib_pkg::ANG_W-1:0]  cos_q
);

    localparam int S = gcib_pkg::CORDIC_STAGES;
    localparam int W = gcib_pkg::TRIG_W;

    logic signed [W-1:0] x_reg [0:S];
    logic signed [W-1:0] y_reg [0:S];
    logic signed [W-1:0] z_reg [0:S];
    logic                flip_reg [0:S];
    gcib_pkg::tag_t      tag_reg [0:S];
    logic signed [W-1:0] x_next [0:S];
    logic signed [W-1:0] y_next [0:S];
    logic signed [W-1:0] z_next [0:S];
    logic                flip_next;
    logic signed [gcib_pkg::ANG_W-1:0] sin_reg, cos_reg;
    gcib_pkg::tag_t      tag_out_reg;

    // fold the angle into the right half plane
    always_comb
    begin
        z_next[0] = $signed({angle[gcib_pkg::ANG_W-1], angle});
        flip_next = 1'b0;
        if (z_next[0] > $signed(33'sh040000000))
        begin
            z_next[0] = z_next[0] - $signed(33'sh080000000);
            flip_next = 1'b1;
        end
        else if (z_next[0] < -$signed(33'sh040000000))
        begin
            z_next[0] = z_next[0] + $signed(33'sh080000000);
            flip_next = 1'b1;
        end
        x_next[0] = $signed({1'b0, gcib_pkg::GAIN_INV});
        y_next[0] = '0;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next[0];
        y_reg[0]    <= y_next[0];
        z_reg[0]    <= z_next[0];
        flip_reg[0] <= flip_next;
    end

    for (genvar i = 0; i < S; i++)
    begin : g_stage
        logic signed [W-1:0] ang;
        assign ang = $signed({{(W-gcib_pkg::ATAN_W){1'b0}}, gcib_pkg::atan_entry(5'(i))});

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ang;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next[i+1];
            y_reg[i+1]    <= y_next[i+1];
            z_reg[i+1]    <= z_next[i+1];
            flip_reg[i+1] <= flip_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i+1] <= '0;
            end
            else
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0]  <= '0;
            tag_out_reg <= '0;
        end
        else
        begin
            tag_reg[0]  <= tag_in;
            tag_out_reg <= tag_reg[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flip_reg[S])
        begin
            sin_reg <= gcib_pkg::ANG_W'(-y_reg[S]);
            cos_reg <= gcib_pkg::ANG_W'(-x_reg[S]);
        end
        else
        begin
            sin_reg <= gcib_pkg::ANG_W'(y_reg[S]);
            cos_reg <= gcib_pkg::ANG_W'(x_reg[S]);
        end
    end

    assign sin_q   = sin_reg;
    assign cos_q   = cos_reg;
    assign tag_out = tag_out_reg;

endmodule
`default_nettype wire

// File: rtl/gcib_atan2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcib_atan2
// Pipelined vectoring-mode CORDIC: angle of (x, y) as a 32-bit binary angle.
// ----------------------------------------------------------------------------
module gcib_atan2 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gcib_pkg::tag_t                tag_in,
    input  wire logic signed [gcib_pkg::VEC_W-1:0] x_in,
    input  wire logic signed [gcib_pkg::VEC_W-1:0] y_in,
    output gcib_pkg::tag_t                     tag_out,
    output logic [gcib_pkg::ANG_W-1:0]         angle
);

    localparam int S  = gcib_pkg::CORDIC_STAGES;
    localparam int W  = gcib_pkg::VEC_W;
    localparam int ZW = gcib_pkg::ANG_W + 3;

    logic signed [W-1:0]  x_reg [0:S];
    logic signed [W-1:0]  y_reg [0:S];
    logic signed [ZW-1:0] z_reg [0:S];
    gcib_pkg::tag_t       tag_reg [0:S];
    logic signed [W-1:0]  x_next [0:S];
    logic signed [W-1:0]  y_next [0:S];
    logic signed [ZW-1:0] z_next [0:S];

    // move a left-half vector to the right half, starting from half a turn
    always_comb
    begin
        if (x_in < 0)
        begin
            x_next[0] = -x_in;
            y_next[0] = -y_in;
            z_next[0] = $signed(35'sh080000000);
        end
        else
        begin
            x_next[0] = x_in;
            y_next[0] = y_in;
            z_next[0] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x_next[0];
        y_reg[0] <= y_next[0];
        z_reg[0] <= z_next[0];
    end

    for (genvar i = 0; i < S; i++)
    begin : g_stage
        logic signed [ZW-1:0] ang;
        assign ang = $signed({{(ZW-gcib_pkg::ATAN_W){1'b0}}, gcib_pkg::atan_entry(5'(i))});

        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ang;
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ang;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next[i+1];
            y_reg[i+1] <= y_next[i+1];
            z_reg[i+1] <= z_next[i+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i+1] <= '0;
            end
            else
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
        end
    end

    assign angle   = z_reg[S][gcib_pkg::ANG_W-1:0];
    assign tag_out = tag_reg[S];

endmodule
`default_nettype wire

// File: rtl/gcib_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcib_back
// Bearing datapath: sines and cosines, the x/y products, atan2 and the
// conversion to tenths of a degree. Takes one item per cycle, never stalls.
// ----------------------------------------------------------------------------
module gcib_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire gcib_pkg::item_t               item,
    output logic                               done,
    output logic [gcib_pkg::TENTHS_W-1:0]      bearing_tenths
);

    localparam int AW = gcib_pkg::ANG_W;
    localparam int VW = gcib_pkg::VEC_W;
    localparam int TW = gcib_pkg::TENTHS_W;
    localparam int PW = 2 * AW;
    localparam int QW = AW + 2;

    gcib_pkg::tag_t tag_in, tag_sc, tag_m1_reg, tag_m2_reg, tag_xy_reg, tag_at;
    logic signed [AW-1:0] s1, c1, s2, c2, sd, cd;

    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [AW-1:0] cd_reg;
    logic signed [QW-1:0] a_reg, y_m2_reg;
    logic signed [QW+AW-1:0] q_reg;
    logic signed [QW-1:0] q_next;
    logic signed [VW-1:0] x_reg, y_reg, x_next, y_next;
    gcib_pkg::tag_t       tag_xy_next;
    logic [AW-1:0]        angle;
    logic [AW+TW-1:0]     scaled;
    logic [TW-1:0]        tenths_next, tenths_reg;
    logic                 done_reg;

    assign tag_in.valid = item_valid;
    assign tag_in.skip  = item.same;

    gcib_sincos u_sc_lat1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .angle   (item.lat1),
        .tag_out (tag_sc),
        .sin_q   (s1),
        .cos_q   (c1)
    );

    gcib_sincos u_sc_lat2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .angle   (item.lat2),
        .tag_out (),
        .sin_q   (s2),
        .cos_q   (c2)
    );

    gcib_sincos u_sc_dlon (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .angle   (item.dlon),
        .tag_out (),
        .sin_q   (sd),
        .cos_q   (cd)
    );

    always_ff @(posedge clk)
    begin
        p1_reg <= c1 * s2;
        p2_reg <= s1 * c2;
        p3_reg <= sd * c2;
        cd_reg <= cd;
    end

    assign q_next = QW'(p2_reg >>> 30);

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next * cd_reg;
        a_reg    <= QW'(p1_reg >>> 30);
        y_m2_reg <= QW'(p3_reg >>> 30);
    end

    always_comb
    begin
        x_next = VW'(a_reg) - VW'(q_reg >>> 30);
        y_next = VW'(y_m2_reg);
        tag_xy_next.valid = tag_m2_reg.valid;
        tag_xy_next.skip  = tag_m2_reg.skip || ((x_next == '0) && (y_next == '0));
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    gcib_atan2 u_atan2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_xy_reg),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .tag_out (tag_at),
        .angle   (angle)
    );

    // round half up to tenths, wrap a full circle to zero; a skipped item gives zero
    always_comb
    begin
        scaled = AW'(angle) * (AW+TW)'(gcib_pkg::FULL_CIRCLE)
               + (AW+TW)'(33'h080000000);
        tenths_next = scaled[AW+TW-1:AW];
        if (tag_at.skip || (tenths_next >= gcib_pkg::FULL_CIRCLE))
        begin
            tenths_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        tenths_reg <= tenths_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_m1_reg <= '0;
            tag_m2_reg <= '0;
            tag_xy_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tag_m1_reg <= tag_sc;
            tag_m2_reg <= tag_m1_reg;
            tag_xy_reg <= tag_xy_next;
            done_reg   <= tag_at.valid;
        end
    end

    assign done           = done_reg;
    assign bearing_tenths = tenths_reg;

endmodule
`default_nettype wire

// File: sim/bearing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bearing_checker
// Watches the bearing block's input and result channels, predicts each
// bearing from the accepted point pair and compares it with the result.
// ----------------------------------------------------------------------------
module bearing_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] from_latitude,
    input  wire logic [31:0] from_longitude,
    input  wire logic [31:0] to_latitude,
    input  wire logic [31:0] to_longitude,
    input  wire logic        done,
    input  wire logic [11:0] bearing_tenths,
    output int               errors,
    output int               pending
);

    localparam int STAGES = gcib_pkg::CORDIC_STAGES;
    localparam longint QUARTER = 64'sd1073741824;
    localparam longint HALF = 64'sd2147483648;
    localparam longint GAIN = 64'sd652032874;

    logic [11:0] bearing_q[$];

    function automatic longint arctan_step(input int k);
        longint tbl[32];
        tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                81, 41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[k & 31];
    endfunction

    function automatic void sin_cos(input logic [31:0] ang, output longint sn,
        output longint cs);
        longint z;
        longint x;
        longint y;
        longint t;
        bit flip;
        z = longint'($signed(ang));
        x = GAIN;
        y = 0;
        flip = 0;
        if (z > QUARTER)
        begin
            z -= HALF;
            flip = 1;
        end
        else if (z < -QUARTER)
        begin
            z += HALF;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> (i & 31));
                y = y + (x >>> (i & 31));
                z -= arctan_step(i);
            end
            else
            begin
                t = x + (y >>> (i & 31));
                y = y - (x >>> (i & 31));
                z += arctan_step(i);
            end
            x = t;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic [11:0] predict_bearing(input logic [31:0] lat1,
        input logic [31:0] lon1, input logic [31:0] lat2, input logic [31:0] lon2);
        longint s1, c1, s2, c2, sd, cd, x, y, z, t;
        logic [63:0] u;
        logic [63:0] tenths;
        if (lat1 == lat2 && lon1 == lon2)
            return 12'd0;
        sin_cos(lat1, s1, c1);
        sin_cos(lat2, s2, c2);
        sin_cos(lon2 - lon1, sd, cd);
        y = (sd * c2) >>> 30;
        x = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
        if (x == 0 && y == 0)
            return 12'd0;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (y >= 0)
            begin
                t = x + (y >>> (i & 31));
                y = y - (x >>> (i & 31));
                z += arctan_step(i);
            end
            else
            begin
                t = x - (y >>> (i & 31));
                y = y + (x >>> (i & 31));
                z -= arctan_step(i);
            end
            x = t;
        end
        u = {32'd0, z[31:0]};
        tenths = (u * 64'd3600 + 64'h8000_0000) >> 32;
        if (tenths >= 64'd3600)
            tenths = 0;
        return tenths[11:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (bearing_q.size() == 0)
                begin
                    $display("%0t: unexpected bearing %0d", $time, bearing_tenths);
                    errors = errors + 1;
                end
                else
                begin
                    if (bearing_q[0] !== bearing_tenths)
                    begin
                        $display("%0t: bearing_tenths expected %0d actual %0d",
                            $time, bearing_q[0], bearing_tenths);
                        errors = errors + 1;
                    end
                    void'(bearing_q.pop_front());
                end
            end
            if (start && !busy)
                bearing_q.push_back(predict_bearing(from_latitude, from_longitude,
                    to_latitude, to_longitude));
            pending = bearing_q.size();
        end
    end

    initial
    begin
        errors = 0;
        pending = 0;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives point pairs into the bearing pipeline with random gaps; the checker
// predicts and compares every bearing.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [31:0] NORTH_POLE = 32'h4000_0000;
    localparam logic [31:0] SOUTH_POLE = 32'hC000_0000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] from_latitude;
    logic [31:0] from_longitude;
    logic [31:0] to_latitude;
    logic [31:0] to_longitude;
    logic        done;
    logic [11:0] bearing_tenths;
    int          errors;
    int          pending;
    bit          no_gaps;

    great_circle_initial_bearing i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .from_latitude(from_latitude), .from_longitude(from_longitude),
        .to_latitude(to_latitude), .to_longitude(to_longitude),
        .done(done), .bearing_tenths(bearing_tenths)
    );

    bearing_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .from_latitude(from_latitude), .from_longitude(from_longitude),
        .to_latitude(to_latitude), .to_longitude(to_longitude),
        .done(done), .bearing_tenths(bearing_tenths),
        .errors(errors), .pending(pending)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    function automatic logic [31:0] rand_lat();
        case ($urandom_range(0, 9))
            0: return NORTH_POLE;
            1: return SOUTH_POLE;
            2: return $urandom();
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    // hold start high until the item is taken; idle first at random
    task automatic send_pair(input logic [31:0] lat1, input logic [31:0] lon1,
        input logic [31:0] lat2, input logic [31:0] lon2);
        while (!no_gaps && $urandom_range(0, 99) < 12)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        from_latitude <= lat1;
        from_longitude <= lon1;
        to_latitude <= lat2;
        to_longitude <= lon2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        rst_n = 0;
        start = 0;
        no_gaps = 0;
        from_latitude = 0;
        from_longitude = 0;
        to_latitude = 0;
        to_longitude = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: identical points, poles, extremes, wrapped longitudes
        send_pair(0, 0, 0, 0);
        send_pair(32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
        send_pair(NORTH_POLE, 0, NORTH_POLE, 32'h4000_0000);
        send_pair(SOUTH_POLE, 5, SOUTH_POLE, 32'h7FFF_FFFF);
        send_pair(0, 0, NORTH_POLE, 0);
        send_pair(0, 0, SOUTH_POLE, 0);
        send_pair(0, 0, 0, 32'h4000_0000);
        send_pair(0, 0, 0, 32'hC000_0000);
        send_pair(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
        send_pair(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(NORTH_POLE, 0, SOUTH_POLE, 32'h8000_0000);
        send_pair(SOUTH_POLE, 0, NORTH_POLE, 0);
        send_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
        send_pair(32'h6000_0000, 32'h1000_0000, 32'hA000_0000, 32'hF000_0000);
        send_pair(32'h2000_0000, 0, 32'h2000_0000, 32'h0000_0100);
        send_pair(0, 0, 32'hFFFF_FF00, 1);
        for (int n = 0; n < 1900; n++)
        begin
            no_gaps = (n >= 600 && n < 900);
            a = rand_lat();
            b = $urandom();
            case ($urandom_range(0, 9))
                0: send_pair(a, b, a, b);
                1: send_pair(a, b, a + $urandom_range(0, 3), b + $urandom_range(0, 3));
                2: send_pair(a, b, -a, b + 32'h8000_0000);
                3: send_pair($urandom(), $urandom(), $urandom(), $urandom());
                default: send_pair(a, b, rand_lat(), $urandom());
            endcase
        end
        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: great_circle_initial_bearing.f
rtl/gcib_pkg.sv
rtl/gcib_front.sv
rtl/gcib_sincos.sv
rtl/gcib_atan2.sv
rtl/gcib_back.sv
rtl/great_circle_initial_bearing.sv
sim/bearing_checker.sv
sim/testbench.sv
